### hw/rtl/bsld_pkg.sv
// bsld_pkg: shared widths, codes, reset values and unit command types
// for the battery short/leak detector. No dependencies.
package bsld_pkg;

    // Stream word widths
    localparam int IN_W  = 128;
    localparam int OUT_W = 24;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int TEMP_W   = 8;
    localparam int OCV_W    = 16;
    localparam int CC_W     = 32;
    localparam int SOC_W    = 14;
    localparam int FCC_W    = 24;
    localparam int STATUS_W = 3;
    localparam int ISC_W    = 20;
    localparam int CHG_W    = 25;

    // Serial arithmetic units
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = 6;
    localparam int MUL_AW    = 41;
    localparam int MUL_BW    = 14;
    localparam int MUL_PW    = MUL_AW + MUL_BW;
    localparam int MUL_CNT_W = 4;

    // Step counts of each serial operation
    localparam logic [DIV_CNT_W-1:0] FCC_DIV_STEPS  = 6'd24;
    localparam logic [DIV_CNT_W-1:0] CHG_DIV_STEPS  = 6'd32;
    localparam logic [DIV_CNT_W-1:0] ISC_DIV_STEPS  = 6'd20;
    localparam logic [MUL_CNT_W-1:0] SOC_MUL_STEPS  = 4'd14;
    localparam logic [MUL_CNT_W-1:0] CC_MUL_STEPS   = 4'd7;
    localparam logic [MUL_CNT_W-1:0] HOUR_MUL_STEPS = 4'd12;

    // Scale constants
    localparam logic [DIV_W-1:0]  PCT_SCALE     = 32'd100;
    localparam logic [MUL_BW-1:0] CC_SCALE      = 14'd100;
    localparam logic [MUL_BW-1:0] SECS_PER_HOUR = 14'd3600;

    // Sample acceptance window
    localparam logic signed [TEMP_W-1:0] TBATT_LOW   = 8'sd10;
    localparam logic signed [TEMP_W-1:0] TBATT_HIGH  = 8'sd45;
    localparam logic [OCV_W-1:0]         OCV_LOW_MV  = 16'd3000;
    localparam logic [OCV_W-1:0]         OCV_HIGH_MV = 16'd4500;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_WAIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FIRST     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RESTARTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_REPORT = 3'd5;
    localparam logic [STATUS_W-1:0] ST_REPORTED  = 3'd6;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_ACT_LOOP        = 3'd0;
    localparam logic [2:0] REG_RECHARGE_CC     = 3'd1;
    localparam logic [2:0] REG_TBAT_DELTA_MAX  = 3'd2;
    localparam logic [2:0] REG_ISC_VALID_MIN   = 3'd3;
    localparam logic [2:0] REG_ISC_VALID_MAX   = 3'd4;
    localparam logic [2:0] REG_ISC_THRESHOLD   = 3'd5;
    localparam logic [2:0] REG_REPORT_CNT_MAX  = 3'd6;
    localparam logic [2:0] REG_REPORT_INTERVAL = 3'd7;

    // Register reset values
    localparam logic [7:0]  RST_ACT_LOOP        = 8'd30;
    localparam logic [23:0] RST_RECHARGE_CC     = 24'd5000;
    localparam logic [6:0]  RST_TBAT_DELTA_MAX  = 7'd10;
    localparam logic [19:0] RST_ISC_VALID_MIN   = 20'd0;
    localparam logic [19:0] RST_ISC_VALID_MAX   = 20'd100000;
    localparam logic [19:0] RST_ISC_THRESHOLD   = 20'd10000;
    localparam logic [7:0]  RST_REPORT_CNT_MAX  = 8'd3;
    localparam logic [31:0] RST_REPORT_INTERVAL = 32'd86400;

    // Unit commands
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
    } div_cmd_t;

    typedef struct packed {
        logic                 start;
        logic [MUL_CNT_W-1:0] count;
    } mul_cmd_t;

endpackage

### hw/rtl/bsld_div.sv
// bsld_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on bsld_pkg.
module bsld_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bsld_pkg::div_cmd_t      cmd,
    input  logic [bsld_pkg::DIV_W-1:0] rem_init,
    input  logic [bsld_pkg::DIV_W-1:0] dividend,
    input  logic [bsld_pkg::DIV_W-1:0] divisor,
    output logic                    done,
    output logic [bsld_pkg::DIV_W-1:0] quot
);
    import bsld_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     q_reg, q_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 fits;

    // One restoring step: shift in next dividend bit, try subtract
    assign trial = {rem_reg, q_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            cnt_next  = cmd.count;
            rem_next  = rem_init;
            q_next    = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            q_next   = {q_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### hw/rtl/bsld_mul.sv
// bsld_mul: bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on bsld_pkg.
module bsld_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bsld_pkg::mul_cmd_t          cmd,
    input  logic [bsld_pkg::MUL_AW-1:0] a_in,
    input  logic [bsld_pkg::MUL_BW-1:0] b_in,
    output logic                        done,
    output logic [bsld_pkg::MUL_PW-1:0] prod
);
    import bsld_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MUL_PW-1:0]    acc_reg, acc_next;
    logic [MUL_PW-1:0]    a_reg, a_next;
    logic [MUL_BW-1:0]    b_reg, b_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            cnt_next  = cmd.count;
            acc_next  = '0;
            a_next    = {{MUL_BW{1'b0}}, a_in};
            b_next    = b_in;
        end else if (busy_reg) begin
            // add shifted multiplicand when the low multiplier bit is set
            acc_next = acc_reg + (b_reg[0] ? a_reg : '0);
            a_next   = {a_reg[MUL_PW-2:0], 1'b0};
            b_next   = {1'b0, b_reg[MUL_BW-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### hw/rtl/battery_short_leak_detector.sv
// Battery short/leak detector: top level with sequencer, state, APB registers.
// Depends on bsld_pkg, bsld_div, bsld_mul.
//
// Usage: each s_ word is one charge-done tick; every act_loop-th tick is a
// sample. Each tick gives exactly one m_ word (status, leakage current in uA,
// report flag). The user writes registers over the APB port only while idle;
// the block itself does not enforce this. A tick that is not a sample, or is
// rejected, goes from the tick check straight to the result register. A sample
// goes through a bit-serial divider and shift-add multiplier, one bit per
// cycle, to be stored or to restart the pair, and on when a current is
// computed (divider steps 24 + 32 + 20, multiplier steps 14 + 7 + 12).
// One tick is worked on at a time; s_tready is high only in idle.
// The result register frees the core: a new tick is taken while the previous
// word still waits; the core then holds its result until m_tready frees the
// register. Reset (aresetn low, synchronous) clears the sample state, the
// report count and time, empties the output and restores register defaults.
module battery_short_leak_detector (
    input  logic                       aclk,
    input  logic                       aresetn,
    // tdata: time_sec[31:0], tbatt_c[39:32], ocv_mv[55:40],
    //        coulomb_count[87:56], ocv_soc[101:88], fcc_uah[125:102], zero pad
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [bsld_pkg::IN_W-1:0]  s_tdata,
    // tdata: status[2:0], isc_ua[22:3], report[23]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [bsld_pkg::OUT_W-1:0] m_tdata,
    // APB register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [4:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import bsld_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_TICK    = 4'd1;
    localparam logic [3:0] S_DIV_FCC = 4'd2;
    localparam logic [3:0] S_MUL_SOC = 4'd3;
    localparam logic [3:0] S_DIV_CHG = 4'd4;
    localparam logic [3:0] S_FIRST   = 4'd5;
    localparam logic [3:0] S_MUL_DCC = 4'd6;
    localparam logic [3:0] S_RC      = 4'd7;
    localparam logic [3:0] S_SUM     = 4'd8;
    localparam logic [3:0] S_MUL_NUM = 4'd9;
    localparam logic [3:0] S_DIV_ISC = 4'd10;
    localparam logic [3:0] S_REPORT  = 4'd11;
    localparam logic [3:0] S_OUT     = 4'd12;

    // ---------------- configuration registers ----------------
    logic [7:0]  act_loop_reg;
    logic [23:0] recharge_cc_reg;
    logic [6:0]  tbat_delta_max_reg;
    logic [19:0] isc_valid_min_reg;
    logic [19:0] isc_valid_max_reg;
    logic [19:0] isc_threshold_reg;
    logic [7:0]  report_cnt_max_reg;
    logic [31:0] report_interval_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_loop_reg        <= RST_ACT_LOOP;
            recharge_cc_reg     <= RST_RECHARGE_CC;
            tbat_delta_max_reg  <= RST_TBAT_DELTA_MAX;
            isc_valid_min_reg   <= RST_ISC_VALID_MIN;
            isc_valid_max_reg   <= RST_ISC_VALID_MAX;
            isc_threshold_reg   <= RST_ISC_THRESHOLD;
            report_cnt_max_reg  <= RST_REPORT_CNT_MAX;
            report_interval_reg <= RST_REPORT_INTERVAL;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_ACT_LOOP:        act_loop_reg        <= pwdata[7:0];
                REG_RECHARGE_CC:     recharge_cc_reg     <= pwdata[23:0];
                REG_TBAT_DELTA_MAX:  tbat_delta_max_reg  <= pwdata[6:0];
                REG_ISC_VALID_MIN:   isc_valid_min_reg   <= pwdata[19:0];
                REG_ISC_VALID_MAX:   isc_valid_max_reg   <= pwdata[19:0];
                REG_ISC_THRESHOLD:   isc_threshold_reg   <= pwdata[19:0];
                REG_REPORT_CNT_MAX:  report_cnt_max_reg  <= pwdata[7:0];
                REG_REPORT_INTERVAL: report_interval_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[4:2])
            REG_ACT_LOOP:        prdata = {24'd0, act_loop_reg};
            REG_RECHARGE_CC:     prdata = {8'd0, recharge_cc_reg};
            REG_TBAT_DELTA_MAX:  prdata = {25'd0, tbat_delta_max_reg};
            REG_ISC_VALID_MIN:   prdata = {12'd0, isc_valid_min_reg};
            REG_ISC_VALID_MAX:   prdata = {12'd0, isc_valid_max_reg};
            REG_ISC_THRESHOLD:   prdata = {12'd0, isc_threshold_reg};
            REG_REPORT_CNT_MAX:  prdata = {24'd0, report_cnt_max_reg};
            REG_REPORT_INTERVAL: prdata = report_interval_reg;
            default:             prdata = '0;
        endcase
    end

    // ---------------- serial units ----------------
    div_cmd_t          div_cmd;
    logic [DIV_W-1:0]  div_rem_init, div_dividend, div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;
    mul_cmd_t          mul_cmd;
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic              mul_done;
    logic [MUL_PW-1:0] mul_prod;

    bsld_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot)
    );

    bsld_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mul_cmd),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // ---------------- state ----------------
    logic [3:0]                 state_reg, state_next;
    logic [7:0]                 tick_reg, tick_next;
    logic                       have_first_reg, have_first_next;
    logic [TIME_W-1:0]          first_time_reg, first_time_next;
    logic signed [TEMP_W-1:0]   first_temp_reg, first_temp_next;
    logic [CHG_W-1:0]           first_chg_reg, first_chg_next;
    logic signed [CC_W-1:0]     first_cc_reg, first_cc_next;
    logic [7:0]                 reports_reg, reports_next;
    logic [TIME_W-1:0]          last_rep_reg, last_rep_next;

    // Latched word
    logic [TIME_W-1:0]          now_reg, now_next;
    logic signed [TEMP_W-1:0]   temp_reg, temp_next;
    logic [OCV_W-1:0]           ocv_reg, ocv_next;
    logic signed [CC_W-1:0]     cc_reg, cc_next;
    logic [SOC_W-1:0]           soc_reg, soc_next;
    logic [FCC_W-1:0]           fcc_reg, fcc_next;

    // Working registers
    logic [CHG_W-1:0]           charge_reg, charge_next;
    logic signed [CHG_W:0]      chg_diff_reg, chg_diff_next;
    logic                       neg_reg, neg_next;
    logic signed [39:0]         dcc_reg, dcc_next;
    logic signed [40:0]         sum_reg, sum_next;
    logic [31:0]                dt_reg, dt_next;
    logic [ISC_W-1:0]           isc_reg, isc_next;

    // Result and output registers
    logic [STATUS_W-1:0]        res_status_reg, res_status_next;
    logic [ISC_W-1:0]           res_isc_reg, res_isc_next;
    logic                       res_rep_reg, res_rep_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]           m_data_reg, m_data_next;

    // Combinational helpers
    logic [7:0]                 tick_inc;
    logic                       range_bad;
    logic signed [CC_W:0]       dcc_raw;
    logic [CC_W:0]              dcc_mag;
    logic signed [TEMP_W:0]     dtemp;
    logic [TEMP_W:0]            dtemp_mag;
    logic signed [TIME_W:0]     dt_full;
    logic [40:0]                sum_mag;
    logic [52:0]                num_mag;
    logic [ISC_W-1:0]           isc_val;
    logic signed [TIME_W:0]     since_rep;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    assign tick_inc  = tick_reg + 8'd1;
    assign range_bad = (temp_reg > TBATT_HIGH) || (temp_reg < TBATT_LOW) ||
                       (ocv_reg > OCV_HIGH_MV) || (ocv_reg <= OCV_LOW_MV);
    assign dcc_raw   = {first_cc_reg[CC_W-1], first_cc_reg} - {cc_reg[CC_W-1], cc_reg};
    assign dcc_mag   = dcc_raw[CC_W] ? (CC_W+1)'(-dcc_raw) : dcc_raw;
    assign dtemp     = {first_temp_reg[TEMP_W-1], first_temp_reg}
                       - {temp_reg[TEMP_W-1], temp_reg};
    assign dtemp_mag = dtemp[TEMP_W] ? (TEMP_W+1)'(-dtemp) : dtemp;
    assign dt_full   = {1'b0, now_reg} - {1'b0, first_time_reg};
    assign sum_mag   = sum_reg[40] ? 41'(-sum_reg) : sum_reg;
    assign num_mag   = mul_prod[52:0];
    assign isc_val   = neg_reg ? '0 : div_quot[ISC_W-1:0];
    assign since_rep = {1'b0, now_reg} - {1'b0, last_rep_reg};

    // ---------------- sequencer ----------------
    always_comb begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        have_first_next = have_first_reg;
        first_time_next = first_time_reg;
        first_temp_next = first_temp_reg;
        first_chg_next  = first_chg_reg;
        first_cc_next   = first_cc_reg;
        reports_next    = reports_reg;
        last_rep_next   = last_rep_reg;
        now_next        = now_reg;
        temp_next       = temp_reg;
        ocv_next        = ocv_reg;
        cc_next         = cc_reg;
        soc_next        = soc_reg;
        fcc_next        = fcc_reg;
        charge_next     = charge_reg;
        chg_diff_next   = chg_diff_reg;
        neg_next        = neg_reg;
        dcc_next        = dcc_reg;
        sum_next        = sum_reg;
        dt_next         = dt_reg;
        isc_next        = isc_reg;
        res_status_next = res_status_reg;
        res_isc_next    = res_isc_reg;
        res_rep_next    = res_rep_reg;
        div_cmd         = '0;
        div_rem_init    = '0;
        div_dividend    = '0;
        div_divisor     = PCT_SCALE;
        mul_cmd         = '0;
        mul_a           = '0;
        mul_b           = '0;

        // result register drains independently of the core
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    now_next   = s_tdata[31:0];
                    temp_next  = s_tdata[39:32];
                    ocv_next   = s_tdata[55:40];
                    cc_next    = s_tdata[87:56];
                    soc_next   = s_tdata[101:88];
                    fcc_next   = s_tdata[125:102];
                    state_next = S_TICK;
                end
            end
            S_TICK: begin
                res_isc_next = '0;
                res_rep_next = 1'b0;
                if (tick_inc < act_loop_reg) begin
                    tick_next       = tick_inc;
                    res_status_next = ST_WAIT;
                    state_next      = S_OUT;
                end else begin
                    tick_next = '0;
                    if (range_bad) begin
                        have_first_next = 1'b0;
                        res_status_next = ST_REJECTED;
                        state_next      = S_OUT;
                    end else begin
                        // fcc / 100, dividend left-aligned
                        div_cmd.start = 1'b1;
                        div_cmd.count = FCC_DIV_STEPS;
                        div_dividend  = {fcc_reg, 8'd0};
                        state_next    = S_DIV_FCC;
                    end
                end
            end
            S_DIV_FCC: begin
                if (div_done) begin
                    mul_cmd.start = 1'b1;
                    mul_cmd.count = SOC_MUL_STEPS;
                    mul_a         = {23'd0, div_quot[17:0]};
                    mul_b         = soc_reg;
                    state_next    = S_MUL_SOC;
                end
            end
            S_MUL_SOC: begin
                if (mul_done) begin
                    div_cmd.start = 1'b1;
                    div_cmd.count = CHG_DIV_STEPS;
                    div_dividend  = mul_prod[31:0];
                    state_next    = S_DIV_CHG;
                end
            end
            S_DIV_CHG: begin
                if (div_done) begin
                    charge_next = div_quot[CHG_W-1:0];
                    state_next  = S_FIRST;
                end
            end
            S_FIRST: begin
                if (!have_first_reg) begin
                    have_first_next = 1'b1;
                    first_time_next = now_reg;
                    first_temp_next = temp_reg;
                    first_chg_next  = charge_reg;
                    first_cc_next   = cc_reg;
                    res_status_next = ST_FIRST;
                    state_next      = S_OUT;
                end else begin
                    chg_diff_next = {1'b0, first_chg_reg} - {1'b0, charge_reg};
                    neg_next      = dcc_raw[CC_W];
                    // coulomb drop scaled to uAh
                    mul_cmd.start = 1'b1;
                    mul_cmd.count = CC_MUL_STEPS;
                    mul_a         = {8'd0, dcc_mag};
                    mul_b         = CC_SCALE;
                    state_next    = S_MUL_DCC;
                end
            end
            S_MUL_DCC: begin
                if (mul_done) begin
                    dcc_next   = neg_reg ? 40'(-$signed(mul_prod[39:0])) : mul_prod[39:0];
                    state_next = S_RC;
                end
            end
            S_RC: begin
                if (dcc_reg >= $signed({16'd0, recharge_cc_reg}) ||
                    dtemp_mag >= {2'd0, tbat_delta_max_reg}) begin
                    // recharge or temperature jump: restart the pair
                    first_time_next = now_reg;
                    first_temp_next = temp_reg;
                    first_chg_next  = charge_reg;
                    first_cc_next   = cc_reg;
                    res_status_next = ST_RESTARTED;
                    state_next      = S_OUT;
                end else begin
                    have_first_next = 1'b0;
                    if (dt_full[TIME_W] || dt_full == '0) begin
                        res_status_next = ST_INVALID;
                        state_next      = S_OUT;
                    end else begin
                        dt_next    = dt_full[TIME_W-1:0];
                        sum_next   = 41'(chg_diff_reg) + 41'(dcc_reg);
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM: begin
                neg_next      = sum_reg[40];
                mul_cmd.start = 1'b1;
                mul_cmd.count = HOUR_MUL_STEPS;
                mul_a         = sum_mag;
                mul_b         = SECS_PER_HOUR;
                state_next    = S_MUL_NUM;
            end
            S_MUL_NUM: begin
                if (mul_done) begin
                    if (num_mag[52:20] >= {1'b0, dt_reg}) begin
                        // quotient magnitude at least 2^20: out of range
                        res_status_next = ST_INVALID;
                        state_next      = S_OUT;
                    end else begin
                        div_cmd.start = 1'b1;
                        div_cmd.count = ISC_DIV_STEPS;
                        div_rem_init  = num_mag[51:20];
                        div_dividend  = {num_mag[19:0], 12'd0};
                        div_divisor   = dt_reg;
                        state_next    = S_DIV_ISC;
                    end
                end
            end
            S_DIV_ISC: begin
                if (div_done) begin
                    if ((neg_reg && div_quot[ISC_W-1:0] != '0) ||
                        isc_val < isc_valid_min_reg || isc_val > isc_valid_max_reg) begin
                        res_status_next = ST_INVALID;
                        state_next      = S_OUT;
                    end else begin
                        isc_next   = isc_val;
                        state_next = S_REPORT;
                    end
                end
            end
            S_REPORT: begin
                res_isc_next    = isc_reg;
                res_status_next = ST_NO_REPORT;
                state_next      = S_OUT;
                if (isc_reg > isc_threshold_reg && reports_reg < report_cnt_max_reg &&
                    (last_rep_reg == '0 ||
                     since_rep >= $signed({1'b0, report_interval_reg}))) begin
                    reports_next    = reports_reg + 8'd1;
                    last_rep_next   = now_reg;
                    res_status_next = ST_REPORTED;
                    res_rep_next    = 1'b1;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {res_rep_reg, res_isc_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and sample state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            tick_reg       <= '0;
            have_first_reg <= 1'b0;
            first_time_reg <= '0;
            first_temp_reg <= '0;
            first_chg_reg  <= '0;
            first_cc_reg   <= '0;
            reports_reg    <= '0;
            last_rep_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            have_first_reg <= have_first_next;
            first_time_reg <= first_time_next;
            first_temp_reg <= first_temp_next;
            first_chg_reg  <= first_chg_next;
            first_cc_reg   <= first_cc_next;
            reports_reg    <= reports_next;
            last_rep_reg   <= last_rep_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        now_reg        <= now_next;
        temp_reg       <= temp_next;
        ocv_reg        <= ocv_next;
        cc_reg         <= cc_next;
        soc_reg        <= soc_next;
        fcc_reg        <= fcc_next;
        charge_reg     <= charge_next;
        chg_diff_reg   <= chg_diff_next;
        neg_reg        <= neg_next;
        dcc_reg        <= dcc_next;
        sum_reg        <= sum_next;
        dt_reg         <= dt_next;
        isc_reg        <= isc_next;
        res_status_reg <= res_status_next;
        res_isc_reg    <= res_isc_next;
        res_rep_reg    <= res_rep_next;
        m_data_reg     <= m_data_next;
    end

endmodule

### hw/rtl/bsld_checker.sv
// bsld_checker: port-level assertions for the detector, bound to the top.
// Depends on bsld_pkg and battery_short_leak_detector.
module bsld_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [bsld_pkg::IN_W-1:0]  s_tdata,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [bsld_pkg::OUT_W-1:0] m_tdata,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [4:0]                 paddr,
    input logic [31:0]                pwdata,
    input logic [31:0]                prdata,
    input logic                       pready
);
    import bsld_pkg::*;

    // Output empties on reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // Stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // Report flag set exactly with reported status
    a_report_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23] == (m_tdata[2:0] == ST_REPORTED)))
        else $error("report flag disagrees with status");

    // Current is zero unless a valid current was computed
    a_isc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != ST_NO_REPORT) && (m_tdata[2:0] != ST_REPORTED)
        |-> (m_tdata[22:3] == '0))
        else $error("current nonzero without a valid estimate");

endmodule

bind battery_short_leak_detector bsld_checker u_bsld_checker (.*);
